// ===== rtl/rcdr_pkg.sv =====
// Shared constants and the raised-cosine lookup table for the dot renderer.
package rcdr_pkg;

  localparam int MAX_DOTS    = 256;
  localparam int COS_ENTRIES = 1024;
  localparam int DOT_AW      = $clog2(MAX_DOTS);
  localparam int COS_AW      = $clog2(COS_ENTRIES);
  localparam int N1          = COS_ENTRIES - 1;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  localparam logic [24:0] SUM_MAX = 25'd16777216;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // (2n-1)*(2n) for Taylor terms n = 1 .. 14
  localparam logic [63:0] TAYLOR_DIV [14] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182,
    64'd240, 64'd306, 64'd380, 64'd462, 64'd552, 64'd650, 64'd756
  };

  typedef logic [16:0] cos_tab_t [COS_ENTRIES];

  // Q1.16 value of (1 + cos(pi*k/N1)) / 2, from a fixed-point Taylor series
  function automatic logic [16:0] hann_term(int unsigned k);
    logic [63:0] m;
    logic [63:0] phi;
    logic [63:0] phi2;
    logic [63:0] t;
    longint      c;
    longint      half;
    bit          refl;
    m    = 64'(k);
    refl = 1'b0;
    if (2 * k > N1) begin
      m    = 64'(N1 - k);
      refl = 1'b1;
    end
    phi  = (PI_Q30 * m) / N1;
    phi2 = (phi * phi) >> 30;
    t    = ONE_Q30;
    c    = longint'(ONE_Q30);
    for (int n = 1; n <= 14; n++) begin
      t  = ((t * phi2) >> 30) / TAYLOR_DIV[n - 1];
      if (n % 2 == 1) c = c - longint'(t);
      else c = c + longint'(t);
    end
    if (c < 0) c = 0;
    if (c > longint'(ONE_Q30)) c = longint'(ONE_Q30);
    half = refl ? (longint'(ONE_Q30) - c) : (longint'(ONE_Q30) + c);
    return 17'((half + 16384) >>> 15);
  endfunction

  function automatic cos_tab_t build_cos_tab();
    cos_tab_t tab;
    for (int k = 0; k < COS_ENTRIES; k++) begin
      tab[k] = hann_term(k);
    end
    return tab;
  endfunction

  localparam cos_tab_t COS_TAB = build_cos_tab();

endpackage

// ===== rtl/raised_cosine_dot_renderer.sv =====
// Top level of the raised-cosine dot renderer: dot table, divider and accumulator.
//
// A write word stores one dot (corner and size) in the on-chip dot table. A
// query word walks table entries 0 .. dot_count-1 (dot_count capped at the
// table depth), one entry at a time: a table read, a window test, a 16-step
// bit-serial divider that makes u for both axes at once, a constant multiply
// for the cosine table index, a registered cosine table read, one 17x17
// multiply and the saturating add. After the last entry the result waits in
// the done state until the output register is free; in_stall is held for the
// whole query, so the next word is taken only once the result has moved on. A
// query with a count of zero goes straight to the done state and returns zero.
// The result sits in an output register, so a new word can be accepted while
// the previous result waits. The table has no reset; only written entries
// may be summed.
module raised_cosine_dot_renderer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [8:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [7:0]  entry_index,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic [22:0] size_w,
  input  logic [22:0] size_h,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [24:0] intensity
);

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_LOAD, S_DIV, S_IDX, S_ROM, S_MUL, S_ACC, S_DONE
  } state_t;

  state_t state;

  logic [8:0]  dot_count;
  logic [93:0] dot_mem [rcdr_pkg::MAX_DOTS];
  logic [93:0] rd_data;

  logic [8:0]  dot_i;
  logic [8:0]  dot_cnt;
  logic signed [23:0] qx;
  logic signed [23:0] qy;
  logic [22:0] sx;
  logic [22:0] sy;
  logic        hit_x;
  logic        hit_y;
  logic [25:0] rem_x;
  logic [25:0] rem_y;
  logic [16:0] quo_x;
  logic [16:0] quo_y;
  logic [3:0]  step;
  logic [rcdr_pkg::COS_AW-1:0] idx_x;
  logic [rcdr_pkg::COS_AW-1:0] idx_y;
  logic [16:0] tx;
  logic [16:0] ty;
  logic [33:0] prod;
  logic [24:0] sum;

  // window test and doubled distance from the centre, per axis
  logic signed [26:0] dd_x;
  logic signed [26:0] dd_y;
  logic [25:0] ad_x;
  logic [25:0] ad_y;
  logic signed [23:0] cx;
  logic signed [23:0] cy;
  logic [22:0] w_rd;
  logic [22:0] h_rd;

  assign cx   = rd_data[93:70];
  assign cy   = rd_data[69:46];
  assign w_rd = rd_data[45:23];
  assign h_rd = rd_data[22:0];

  always_comb begin
    dd_x = 27'(2 * 27'(qx)) - 27'(2 * 27'(cx)) - 27'({4'b0, w_rd});
    dd_y = 27'(2 * 27'(qy)) - 27'(2 * 27'(cy)) - 27'({4'b0, h_rd});
    ad_x = dd_x[26] ? 26'(-dd_x) : dd_x[25:0];
    ad_y = dd_y[26] ? 26'(-dd_y) : dd_y[25:0];
  end

  // one divider step: integer part first, then one fraction bit a cycle
  function automatic logic [43:0] div_step(logic [25:0] r, logic [16:0] q,
                                           logic [22:0] s, logic first);
    logic [25:0] s1;
    logic [25:0] s2;
    logic [25:0] r2;
    logic [25:0] rn;
    logic [16:0] qn;
    s1 = {3'b0, s};
    s2 = {2'b0, s, 1'b0};
    if (first) begin
      if (r >= s2) begin
        rn = r - s2;
        qn = 17'd2;
      end else if (r >= s1) begin
        rn = r - s1;
        qn = 17'd1;
      end else begin
        rn = r;
        qn = 17'd0;
      end
    end else begin
      r2 = {r[24:0], 1'b0};
      if (r2 >= s1) begin
        rn = r2 - s1;
        qn = {q[15:0], 1'b1};
      end else begin
        rn = r2;
        qn = {q[15:0], 1'b0};
      end
    end
    return {rn, qn[16:0], 1'b0};
  endfunction

  logic [43:0] dx_res;
  logic [43:0] dy_res;
  logic [27:0] ix_full;
  logic [27:0] iy_full;
  logic [16:0] add_term;
  logic [25:0] sum_wide;
  logic [24:0] sum_next;
  logic        done_ok;

  always_comb begin
    dx_res   = div_step(rem_x, quo_x, sx, step == 4'd0);
    dy_res   = div_step(rem_y, quo_y, sy, step == 4'd0);
    ix_full  = 28'(quo_x) * 28'(rcdr_pkg::N1) + 28'd32768;
    iy_full  = 28'(quo_y) * 28'(rcdr_pkg::N1) + 28'd32768;
    add_term = 17'((prod + 34'd32768) >> 16);
    sum_wide = 26'(sum) + 26'(add_term);
    if (!(hit_x && hit_y)) sum_next = sum;
    else if (sum_wide > 26'(rcdr_pkg::SUM_MAX)) sum_next = rcdr_pkg::SUM_MAX;
    else sum_next = sum_wide[24:0];
    done_ok  = !out_valid || !out_stall;
  end

  assign in_stall = (state != S_IDLE);

  // dot table
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid && operation == rcdr_pkg::OP_WRITE) begin
      dot_mem[entry_index[rcdr_pkg::DOT_AW-1:0]] <= {pos_x, pos_y, size_w, size_h};
    end
    rd_data <= dot_mem[dot_i[rcdr_pkg::DOT_AW-1:0]];
  end

  // cosine table reads
  always_ff @(posedge clk) begin
    tx <= rcdr_pkg::COS_TAB[idx_x];
    ty <= rcdr_pkg::COS_TAB[idx_y];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      dot_count <= 9'd0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) dot_count <= cfg_data;
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && operation == rcdr_pkg::OP_QUERY) begin
            qx    <= pos_x;
            qy    <= pos_y;
            dot_i <= 9'd0;
            sum   <= 25'd0;
            if (dot_count > 9'(rcdr_pkg::MAX_DOTS)) dot_cnt <= 9'(rcdr_pkg::MAX_DOTS);
            else dot_cnt <= dot_count;
            if (dot_count == 9'd0) state <= S_DONE;
            else state <= S_READ;
          end
        end
        S_READ: state <= S_LOAD;
        S_LOAD: begin
          sx    <= w_rd;
          sy    <= h_rd;
          hit_x <= (w_rd != 23'd0) && (ad_x <= {2'b0, w_rd, 1'b0});
          hit_y <= (h_rd != 23'd0) && (ad_y <= {2'b0, h_rd, 1'b0});
          rem_x <= ad_x;
          rem_y <= ad_y;
          quo_x <= 17'd0;
          quo_y <= 17'd0;
          step  <= 4'd0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem_x <= dx_res[43:18];
          quo_x <= dx_res[17:1];
          rem_y <= dy_res[43:18];
          quo_y <= dy_res[17:1];
          step  <= step + 4'd1;
          if (step == 4'd15) state <= S_IDX;
        end
        S_IDX: begin
          idx_x <= ix_full[16 +: rcdr_pkg::COS_AW];
          idx_y <= iy_full[16 +: rcdr_pkg::COS_AW];
          state <= S_ROM;
        end
        S_ROM: state <= S_MUL;
        S_MUL: begin
          prod  <= 34'(tx) * 34'(ty);
          state <= S_ACC;
        end
        S_ACC: begin
          sum <= sum_next;
          if (dot_i == dot_cnt - 9'd1) begin
            state <= S_DONE;
          end else begin
            dot_i <= dot_i + 9'd1;
            state <= S_READ;
          end
        end
        S_DONE: begin
          // hold the result until the output register is free
          if (done_ok) begin
            out_valid <= 1'b1;
            intensity <= sum;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
